// ===== hw/rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: request and response
// item layouts, operation kinds and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    // field widths
    localparam int KIND_W  = 3;
    localparam int POS_W   = 11;
    localparam int WORD_W  = 32;
    localparam int LEN_W   = 11;

    // default number of list entries
    localparam int DEPTH_DEFAULT = 1024;

    // operation kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd5;

    // status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // request item
    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word;
    } req_t;

    // response item
    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        status_t                  status;
        logic [LEN_W-1:0]         length;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_list_store_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Ordered list of signed words in a single-port-write, registered-read
// memory, with read, write, append, insert, remove and pop requests.
// ----------------------------------------------------------------------------
// Read and pop read the memory on accept and take the word in S_RWAIT before
//   S_DONE; write, append, errors and unknown kinds go straight to S_DONE.
// Insert at p shifts entries up from the end (S_UP) and then writes the word
//   (S_PLACE); remove captures word p and shifts later entries down (S_DN).
//   Shifts move one entry per cycle via the one read and one write port.
// One item is in work at a time; a finished response waits in the output
//   register while the next item is accepted.
// Reset clears the length and control state; memory contents are not reset.
`default_nettype none

module indexed_list_store_unit
    import ils_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RWAIT = 6'b000010,
        S_UP    = 6'b000100,
        S_PLACE = 6'b001000,
        S_DN    = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            cur_reg, cur_next;
    logic [AW-1:0]            wa_reg, wa_next;
    logic                     pend_reg, pend_next;
    logic                     first_reg, first_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic signed [WORD_W-1:0] word_reg, word_next;
    logic signed [WORD_W-1:0] res_word_reg, res_word_next;
    status_t                  res_st_reg, res_st_next;
    rsp_t                     rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    // memory port signals
    logic signed [WORD_W-1:0] mem_reg [DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_wa;
    logic signed [WORD_W-1:0] mem_wd;
    logic [AW-1:0]            mem_ra;

    logic [CMPW-1:0]          req_pos_w;
    logic [CMPW-1:0]          cnt_w;
    logic                     is_full;
    logic                     is_empty;

    assign req_pos_w = CMPW'(req.position);
    assign cnt_w     = CMPW'(count_reg);
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // list memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_reg[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem_reg[mem_ra];
    end

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        wa_next        = wa_reg;
        pend_next      = pend_reg;
        first_next     = first_reg;
        pos_next       = pos_reg;
        word_next      = word_reg;
        res_word_next  = res_word_reg;
        res_st_next    = res_st_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        mem_wa         = wa_reg;
        mem_wd         = rdata_reg;
        mem_ra         = '0;

        // response taken
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pos_next      = req.position;
                    word_next     = req.word;
                    res_word_next = '0;
                    res_st_next   = ST_OK;
                    pend_next     = 1'b0;
                    first_next    = 1'b0;
                    state_next    = S_DONE;
                    case (req.kind)
                        KIND_READ:
                        begin
                            if (req_pos_w < cnt_w)
                            begin
                                mem_ra     = AW'(req.position);
                                state_next = S_RWAIT;
                            end
                            else
                            begin
                                res_st_next = ST_INDEX;
                            end
                        end
                        KIND_WRITE:
                        begin
                            if (req_pos_w < cnt_w)
                            begin
                                mem_we = 1'b1;
                                mem_wa = AW'(req.position);
                                mem_wd = req.word;
                            end
                            else
                            begin
                                res_st_next = ST_INDEX;
                            end
                        end
                        KIND_APPEND:
                        begin
                            if (is_full)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = AW'(count_reg);
                                mem_wd     = req.word;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (req_pos_w > cnt_w)
                            begin
                                res_st_next = ST_INDEX;
                            end
                            else if (is_full)
                            begin
                                res_st_next = ST_FULL;
                            end
                            else
                            begin
                                cur_next   = count_reg;
                                state_next = S_UP;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                res_st_next = ST_EMPTY;
                            end
                            else if (req_pos_w >= cnt_w)
                            begin
                                res_st_next = ST_INDEX;
                            end
                            else
                            begin
                                mem_ra     = AW'(req.position);
                                cur_next   = CW'(req.position);
                                first_next = 1'b1;
                                state_next = S_DN;
                            end
                        end
                        KIND_POP:
                        begin
                            if (is_empty)
                            begin
                                res_st_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                mem_ra     = AW'(count_reg - 1'b1);
                                state_next = S_RWAIT;
                            end
                        end
                        default:
                        begin
                            res_st_next = ST_OK;
                        end
                    endcase
                end
            end

            // read data arrives in the cycle after the address is given
            S_RWAIT:
            begin
                res_word_next = rdata_reg;
                state_next    = S_DONE;
            end

            // shift entries up, from the end down to the insert point
            S_UP:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (CMPW'(cur_reg) > CMPW'(pos_reg))
                begin
                    mem_ra    = AW'(cur_reg - 1'b1);
                    pend_next = 1'b1;
                    wa_next   = AW'(cur_reg);
                    cur_next  = cur_reg - 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_PLACE;
                end
            end

            // drop the new word into the gap
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_wa     = AW'(pos_reg);
                mem_wd     = word_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            // capture the removed word, then shift later entries down
            S_DN:
            begin
                if (first_reg)
                begin
                    res_word_next = rdata_reg;
                    first_next    = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (CW'(cur_reg + 1'b1) < count_reg)
                begin
                    mem_ra    = AW'(cur_reg + 1'b1);
                    pend_next = 1'b1;
                    wa_next   = AW'(cur_reg);
                    cur_next  = cur_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.read_word = res_word_reg;
                    rsp_next.status    = res_st_reg;
                    rsp_next.length    = LEN_W'(count_reg);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        wa_reg       <= wa_next;
        pos_reg      <= pos_next;
        word_reg     <= word_next;
        res_word_reg <= res_word_next;
        res_st_reg   <= res_st_next;
        rsp_reg      <= rsp_next;
    end

`ifndef SYNTH
    // length never exceeds the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("list length exceeds depth");

    // an accepted pop on a nonempty list shortens it by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.kind == KIND_POP && !is_empty)
        |=> (count_reg == CW'($past(count_reg) - 1'b1)))
        else $error("pop did not shorten list");

    // a full status is only handed out while the store is full
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && res_st_reg == ST_FULL) |-> is_full)
        else $error("full status with free space");

    // no memory write while waiting for a new item
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !req_valid) |-> !mem_we)
        else $error("memory written while idle");
`endif

endmodule

`default_nettype wire
